// ----- rtl/ptorch_pkg.sv -----
// Shared types, widths and codes for the plasma torch height controller.
`timescale 1ns / 1ps
`default_nettype none
package ptorch_pkg;

    // Field and state widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned VOLT_W    = 10;
    localparam int unsigned HYST_W    = 10;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned EDGE_W    = 16;
    localparam int unsigned WIN_W     = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned SUM_W     = 26;
    localparam int unsigned AVG_W     = 14;
    localparam int unsigned FRAC_W    = 4;     // Q.4 fraction bits

    localparam int unsigned WINDOW_TICKS_DEFAULT = 250;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CTRL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIERCE_MS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0]  FREQ_LOW_RST   = 16'd8000;
    localparam logic [CFG_W-1:0]  FREQ_HIGH_RST  = 16'd12000;
    localparam logic [CFG_W-1:0]  PIERCE_MS_RST  = 16'd500;
    localparam logic [CFG_W-1:0]  AVERAGE_MS_RST = 16'd1000;
    localparam logic [HYST_W-1:0] HYST_RST       = 10'd5;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              torch_request;
        logic              arc_detect;
        logic [VOLT_W-1:0] arc_voltage;
    } t_in_item;

    typedef struct packed {
        logic torch_enable;
        logic arc_ok_out;
        logic z_up;
        logic z_down;
        logic ready_res;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic arm;
        logic cmp;
        logic avg_load;
        logic out_load;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_arm;
        logic go_cmp;
        logic sample;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- rtl/ptorch_if.sv -----
// Valid/ready channel interfaces for input and result transactions.
`timescale 1ns / 1ps
`default_nettype none
interface ptorch_in_if;
    logic                 valid;
    logic                 ready;
    ptorch_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ptorch_out_if;
    logic                  valid;
    logic                  ready;
    ptorch_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ptorch_div.sv -----
// Restoring divider, one quotient bit per cycle, for the Q.4 voltage average.
`timescale 1ns / 1ps
`default_nettype none
module ptorch_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ptorch_pkg::SUM_W-1:0]    i_dividend,
    input  logic [ptorch_pkg::COUNT_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [ptorch_pkg::AVG_W-1:0]    o_quot
);
    import ptorch_pkg::*;

    localparam int unsigned EXT_W  = SUM_W + FRAC_W;
    localparam int unsigned STEP_W = $clog2(AVG_W);

    // The average never exceeds the largest sample, so the quotient fits in
    // AVG_W bits and the upper dividend bits already lie below the divisor.
    logic [EXT_W-1:0]   dividend_x;
    logic [COUNT_W-1:0] r_rem, n_rem;
    logic [AVG_W-1:0]   r_q, n_q;
    logic [COUNT_W-1:0] r_div;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_done;
    logic [COUNT_W:0]   rem_sh;
    logic               ge;

    assign dividend_x = {i_dividend, {FRAC_W{1'b0}}};

    // One restoring step
    always_comb begin
        rem_sh = {r_rem, r_q[AVG_W-1]};
        ge     = (rem_sh >= {1'b0, r_div});
        n_rem  = ge ? COUNT_W'(rem_sh - {1'b0, r_div}) : COUNT_W'(rem_sh);
        n_q    = {r_q[AVG_W-2:0], ge};
    end

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(AVG_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= dividend_x[EXT_W-1 -: COUNT_W];
            r_q   <= dividend_x[AVG_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ----- rtl/ptorch_dp.sv -----
// Datapath: edge window, millisecond clock, averaging, Z control, result register.
`timescale 1ns / 1ps
`default_nettype none
module ptorch_dp #(
    parameter int unsigned WINDOW_TICKS = ptorch_pkg::WINDOW_TICKS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptorch_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptorch_pkg::CFG_W-1:0]      i_cfg_data,
    input  ptorch_pkg::t_in_item              i_item,
    input  ptorch_pkg::t_ctrl_cmd             i_cmd,
    output ptorch_pkg::t_dp_stat              o_stat,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output ptorch_pkg::t_out_item             o_out_data
);
    import ptorch_pkg::*;

    localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(WINDOW_TICKS);

    // Configuration registers
    logic [CFG_W-1:0]  r_freq_low, r_freq_high, r_pierce_ms, r_average_ms;
    logic [HYST_W-1:0] r_hyst;

    // Latched transaction
    t_in_item r_item;

    // Block state
    logic [EDGE_W-1:0]  r_edge_count;
    logic [WIN_W-1:0]   r_window;
    logic               r_ready_flag;
    logic [TIME_W-1:0]  r_now;
    logic               r_arc_ok;
    logic               r_armed;
    logic [TIME_W-1:0]  r_measure_start;
    logic [TIME_W-1:0]  r_control_start;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [AVG_W-1:0]   r_avg;
    logic               r_z_up, r_z_down;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic               clr;
    logic               arc_ok_n;
    logic               is_ctrl;
    logic [WIN_W:0]     window_inc;
    logic [EDGE_W:0]    doubled;
    logic [SUM_W-1:0]   sum_n;
    logic [COUNT_W-1:0] count_n;
    logic [AVG_W-1:0]   v_q4, h_q4;
    logic [AVG_W:0]     upper_th, lower_v;
    logic               div_done;
    logic [AVG_W-1:0]   div_quot;

    // Configuration writes, taken in any state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_low   <= FREQ_LOW_RST;
            r_freq_high  <= FREQ_HIGH_RST;
            r_pierce_ms  <= PIERCE_MS_RST;
            r_average_ms <= AVERAGE_MS_RST;
            r_hyst       <= HYST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FREQ_LOW:   r_freq_low   <= i_cfg_data;
                REG_FREQ_HIGH:  r_freq_high  <= i_cfg_data;
                REG_PIERCE_MS:  r_pierce_ms  <= i_cfg_data;
                REG_AVERAGE_MS: r_average_ms <= i_cfg_data;
                REG_HYSTERESIS: r_hyst       <= i_cfg_data[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    // Transaction latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
    end

    // Decode of the latched control step
    assign is_ctrl    = (r_item.cmd == CMD_CTRL);
    assign clr        = r_item.torch_request && !r_arc_ok;
    assign arc_ok_n   = r_item.arc_detect && r_item.torch_request;
    assign window_inc = {1'b0, r_window} + 1'b1;
    assign doubled    = {r_edge_count, 1'b0};

    // Sample accumulate
    assign sum_n   = r_sum + SUM_W'(r_item.arc_voltage);
    assign count_n = r_count + 1'b1;

    // Hysteresis compare in Q.4
    assign v_q4     = {r_item.arc_voltage, {FRAC_W{1'b0}}};
    assign h_q4     = {r_hyst, {FRAC_W{1'b0}}};
    assign upper_th = {1'b0, r_avg} + {1'b0, h_q4};
    assign lower_v  = {1'b0, v_q4} + {1'b0, h_q4};

    // Status toward the controller
    always_comb begin
        o_stat.need_arm = is_ctrl && arc_ok_n && (clr || !r_armed);
        o_stat.go_cmp   = is_ctrl && arc_ok_n;
        o_stat.sample   = (r_now > r_measure_start) && (r_now < r_control_start)
                          && (r_count != {COUNT_W{1'b1}});
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // Architectural state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count    <= '0;
            r_window        <= '0;
            r_ready_flag    <= 1'b0;
            r_now           <= '0;
            r_arc_ok        <= 1'b0;
            r_armed         <= 1'b0;
            r_measure_start <= '0;
            r_control_start <= '0;
            r_count         <= '0;
            r_sum           <= '0;
            r_avg           <= '0;
            r_z_up          <= 1'b0;
            r_z_down        <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                case (r_item.cmd)
                    CMD_EDGE: begin
                        if (r_edge_count != {EDGE_W{1'b1}}) begin
                            r_edge_count <= r_edge_count + 1'b1;
                        end
                    end
                    CMD_TICK: begin
                        r_now <= r_now + 1'b1;
                        if (window_inc >= {1'b0, WIN_LAST}) begin
                            r_ready_flag <= (doubled > {1'b0, r_freq_low})
                                            && (doubled < {1'b0, r_freq_high});
                            r_edge_count <= '0;
                            r_window     <= '0;
                        end else begin
                            r_window <= window_inc[WIN_W-1:0];
                        end
                    end
                    CMD_CTRL: begin
                        if (clr) begin
                            r_armed         <= 1'b0;
                            r_control_start <= '0;
                            r_count         <= '0;
                            r_sum           <= '0;
                            r_avg           <= '0;
                        end
                        r_arc_ok <= arc_ok_n;
                        if (!arc_ok_n) begin
                            r_z_up   <= 1'b0;
                            r_z_down <= 1'b0;
                            if (clr) begin
                                r_measure_start <= '0;
                            end
                        end else if (clr || !r_armed) begin
                            r_measure_start <= r_now + TIME_W'(r_pierce_ms);
                        end
                    end
                    default: ;
                endcase
            end

            // Second half of arming: end of the averaging interval
            if (i_cmd.arm) begin
                r_control_start <= r_measure_start + TIME_W'(r_average_ms);
                r_armed         <= 1'b1;
            end

            // Sampling or height control against the armed times
            if (i_cmd.cmp) begin
                if (o_stat.sample) begin
                    r_count <= count_n;
                    r_sum   <= sum_n;
                end
                if (r_now > r_control_start) begin
                    if ({1'b0, v_q4} > upper_th) begin
                        r_z_up   <= 1'b0;
                        r_z_down <= 1'b1;
                    end else if (lower_v < {1'b0, r_avg}) begin
                        r_z_up   <= 1'b1;
                        r_z_down <= 1'b0;
                    end else begin
                        r_z_up   <= 1'b0;
                        r_z_down <= 1'b0;
                    end
                end
            end

            if (i_cmd.avg_load) begin
                r_avg <= div_quot;
            end
        end
    end

    // Average = sum * 16 / count
    ptorch_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.cmp && o_stat.sample),
        .i_dividend (sum_n),
        .i_divisor  (count_n),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.torch_enable <= r_item.torch_request && r_ready_flag;
            r_out_data.arc_ok_out   <= r_arc_ok;
            r_out_data.z_up         <= r_z_up;
            r_out_data.z_down       <= r_z_down;
            r_out_data.ready_res    <= r_ready_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule
`default_nettype wire

// ----- rtl/ptorch_ctrl.sv -----
// Controller state machine sequencing one transaction through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module ptorch_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  ptorch_pkg::t_dp_stat   i_stat,
    output logic                   o_in_ready,
    output ptorch_pkg::t_ctrl_cmd  o_cmd
);
    import ptorch_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_ARM   = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0] r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.need_arm) begin
                    n_state = S_ARM;
                end else if (i_stat.go_cmp) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_ARM: begin
                o_cmd.arm = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_stat.sample ? S_DIV : S_WRITE;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.avg_load = 1'b1;
                    n_state        = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/plasma_torch_height_control.sv -----
// Top level of the plasma torch height controller.
//
// Usage:
//   i_in carries one transaction per command: a charge-pump edge, a
//   millisecond tick, a control step or a no-op, with the torch request,
//   arc detect and arc voltage sample. o_out returns exactly one result
//   transaction per input: torch enable, arc ok, Z up, Z down, ready.
//   The configuration port writes a register at each edge with i_cfg_we
//   high; write it only while no transaction is in flight.
// Timing:
//   A transaction is accepted, executed and written out before the next is
//   accepted. A control step with the arc ok adds a time compare, an arm
//   step when it arms the pierce/averaging times, and a divide wait when
//   it takes a voltage sample: the restoring divider that forms the Q.4
//   average produces one quotient bit per cycle, 14 bits. A step that
//   arms never samples.
// Reset: synchronous, active low; clears all state, loads register defaults.
// Stall: the result register holds while o_out.ready is low; one more input
//   is accepted and computed, then the block waits to deliver it.
`timescale 1ns / 1ps
`default_nettype none
module plasma_torch_height_control #(
    parameter int unsigned WINDOW_TICKS = ptorch_pkg::WINDOW_TICKS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptorch_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptorch_pkg::CFG_W-1:0]      i_cfg_data,
    ptorch_in_if.sink                         i_in,
    ptorch_out_if.source                      o_out
);
    import ptorch_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    ptorch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (dp_stat),
        .o_in_ready (in_ready),
        .o_cmd      (ctrl_cmd)
    );

    ptorch_dp #(
        .WINDOW_TICKS (WINDOW_TICKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in.data),
        .i_cmd       (ctrl_cmd),
        .o_stat      (dp_stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_data)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_data;
endmodule
`default_nettype wire

// ----- rtl/ptorch_chk.sv -----
// Port-level checker for the height controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ptorch_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input ptorch_pkg::t_out_item i_out_data
);
    import ptorch_pkg::*;

    // Result register empties at reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Z motion is never commanded both ways
    a_z_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.z_up && i_out_data.z_down))
        else $error("z up and z down together");

    // Z motion only while the arc is ok
    a_z_needs_arc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.z_up || i_out_data.z_down)
        |-> i_out_data.arc_ok_out)
        else $error("z motion without arc ok");

    // Torch is only enabled with the charge pump in band
    a_torch_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.torch_enable |-> i_out_data.ready_res)
        else $error("torch enabled while not ready");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");
endmodule

bind plasma_torch_height_control ptorch_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire
